// File: src/tpc_pkg.sv
// Shared types, constants and register codes of the prewash tank controller.
package tpc_pkg;

  localparam int TIME_BITS_DEF  = 16;
  localparam int COUNT_BITS_DEF = 16;

  localparam int DOSE_BITS = 16;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = 16;

  // Timer presets in 10 ms ticks.
  localparam int LEVEL_DEBOUNCE_TICKS = 500;
  localparam int LEVEL_ERROR_TICKS    = 2000;
  localparam int REFILL_TICKS         = 200;
  localparam int SAFETY_TICKS         = 1000;
  localparam int FLOW_GAP_TICKS       = 300;
  localparam int FLOW_START_TICKS     = 2000;
  localparam int PUMP_CUT_TICKS       = 3000;
  localparam int DOSE_SCALE           = 100;
  // Largest quotient whose scaled value still fits in 16 bits.
  localparam int DOSE_QUOT_MAX        = 65535 / DOSE_SCALE;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_REPLENISH_MODE = 3'd0,
    REG_DOSE_PER_PLATE = 3'd1,
    REG_DOSE_PER_AREA  = 3'd2,
    REG_PUMP_RATE      = 3'd3,
    REG_MIN_VALVE_TIME = 3'd4,
    REG_FLOW_CHECK_EN  = 3'd5
  } tpc_reg_e;

  typedef enum logic [1:0] {
    MODE_PER_PLATE = 2'd0,
    MODE_PER_AREA  = 2'd1,
    MODE_FRESH     = 2'd2,
    MODE_SPARE     = 2'd3
  } tpc_mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_APPLY,
    ST_OUT
  } tpc_state_e;

  typedef struct packed {
    logic load;
    logic mul;
    logic div_step;
    logic apply;
  } tpc_cmd_t;

  typedef struct packed {
    logic div_last;
  } tpc_status_t;

endpackage

// File: src/tpc_if.sv
// Handshake channel interfaces for items, results and configuration writes.
interface tpc_in_if;
  logic       valid;
  logic       ready;
  logic       tank_full;
  logic       second_pulse;
  logic       processing;
  logic       module_present;
  logic       voltage_ok;
  logic       auto_mode;
  logic       flow_present;
  logic [7:0] plates_added;
  logic [7:0] area_added;
  logic       pump_write;
  logic       pump_write_value;

  modport source (output valid, tank_full, second_pulse, processing, module_present,
                  voltage_ok, auto_mode, flow_present, plates_added, area_added,
                  pump_write, pump_write_value, input ready);
  modport sink (input valid, tank_full, second_pulse, processing, module_present,
                voltage_ok, auto_mode, flow_present, plates_added, area_added,
                pump_write, pump_write_value, output ready);
endinterface

interface tpc_out_if;
  logic        valid;
  logic        ready;
  logic        valve_open;
  logic        pump_on;
  logic        pump_command;
  logic        level_out_of_range;
  logic        level_alarm;
  logic        flow_alarm;
  logic [15:0] dose_time;
  logic [15:0] dose_time_left;
  logic        refilling;

  modport source (output valid, valve_open, pump_on, pump_command, level_out_of_range,
                  level_alarm, flow_alarm, dose_time, dose_time_left, refilling,
                  input ready);
  modport sink (input valid, valve_open, pump_on, pump_command, level_out_of_range,
                level_alarm, flow_alarm, dose_time, dose_time_left, refilling,
                output ready);
endinterface

interface tpc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: src/tank_prewash_controller_core.sv
// Top level of the prewash tank controller: controller and datapath.
// One item at a time; an item passes through load, multiply, the divide steps, update
// and output, and the bit-serial dose divider produces one quotient bit per cycle.
// A new item is not taken until the result of the last one has been taken.
// Configuration writes are taken every cycle.
// Reset is asynchronous, active low, and clears all timers, counts and flags.
module tank_prewash_controller_core
  import tpc_pkg::*;
#(
  parameter int TIME_BITS  = TIME_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input logic     clk_i,
  input logic     rst_ni,
  tpc_in_if.sink  in_i,
  tpc_out_if.source out_o,
  tpc_cfg_if.sink cfg_i
);

  tpc_cmd_t    cmd;
  tpc_status_t status;

  assign cfg_i.ready = 1'b1;

  tpc_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  tpc_datapath #(
    .TIME_BITS  (TIME_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .status_o             (status),
    .cfg_we_i             (cfg_i.valid),
    .cfg_index_i          (cfg_i.index),
    .cfg_data_i           (cfg_i.data),
    .tank_full_i          (in_i.tank_full),
    .second_pulse_i       (in_i.second_pulse),
    .processing_i         (in_i.processing),
    .module_present_i     (in_i.module_present),
    .voltage_ok_i         (in_i.voltage_ok),
    .auto_mode_i          (in_i.auto_mode),
    .flow_present_i       (in_i.flow_present),
    .plates_added_i       (in_i.plates_added),
    .area_added_i         (in_i.area_added),
    .pump_write_i         (in_i.pump_write),
    .pump_write_value_i   (in_i.pump_write_value),
    .valve_open_o         (out_o.valve_open),
    .pump_on_o            (out_o.pump_on),
    .pump_command_o       (out_o.pump_command),
    .level_out_of_range_o (out_o.level_out_of_range),
    .level_alarm_o        (out_o.level_alarm),
    .flow_alarm_o         (out_o.flow_alarm),
    .dose_time_o          (out_o.dose_time),
    .dose_time_left_o     (out_o.dose_time_left),
    .refilling_o          (out_o.refilling)
  );

endmodule

// File: src/tpc_datapath.sv
// Datapath: configuration, timers, counts, dose multiply and divide, result registers.
module tpc_datapath
  import tpc_pkg::*;
#(
  parameter int TIME_BITS  = TIME_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  tpc_cmd_t                 cmd_i,
  output tpc_status_t              status_o,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i,
  input  logic                     tank_full_i,
  input  logic                     second_pulse_i,
  input  logic                     processing_i,
  input  logic                     module_present_i,
  input  logic                     voltage_ok_i,
  input  logic                     auto_mode_i,
  input  logic                     flow_present_i,
  input  logic [7:0]               plates_added_i,
  input  logic [7:0]               area_added_i,
  input  logic                     pump_write_i,
  input  logic                     pump_write_value_i,
  output logic                     valve_open_o,
  output logic                     pump_on_o,
  output logic                     pump_command_o,
  output logic                     level_out_of_range_o,
  output logic                     level_alarm_o,
  output logic                     flow_alarm_o,
  output logic [DOSE_BITS-1:0]     dose_time_o,
  output logic [DOSE_BITS-1:0]     dose_time_left_o,
  output logic                     refilling_o
);

  localparam int TB = TIME_BITS;
  localparam int CB = COUNT_BITS;
  localparam int PW = CB + DOSE_BITS;
  localparam int DCW = $clog2(PW);

  typedef logic [TB-1:0] tm_t;

  // Configuration registers.
  logic [1:0]           mode_q;
  logic [DOSE_BITS-1:0] dose_plate_q, dose_area_q, rate_q, min_time_q;
  logic                 fce_q;

  // Latched item fields.
  logic full_q, pulse_q, proc_q, module_q, volt_q, auto_q, flow_q;

  // Model state.
  tm_t ok_et_q, bad_et_q, err_et_q, ref_et_q, saf_et_q, fs_et_q, fg_et_q, cut_et_q;
  tm_t pe_q;
  logic [DOSE_BITS-1:0] plen_q, last_q, held_q;
  logic pa_q, req_q;
  logic m_lok_q, m_lbad_q, m_vr_q, m_vf_q, m_pr_q, m_tpin_q;
  logic [CB-1:0] plate_q, area_q;
  logic f_lnr_q, f_valve_q, f_pump_q, f_cmd_q, f_refill_q, f_flow_q;

  // Divider.
  logic [PW-1:0]        prod_q;
  logic [DOSE_BITS-1:0] rem_q;
  logic [DCW-1:0]       dcnt_q;

  // Result registers.
  logic lalarm_q;
  logic [DOSE_BITS-1:0] left_q;

  function automatic tm_t od_next(tm_t et, logic en, int pt);
    tm_t r;
    r = '0;
    if (en) begin
      r = (et < TB'(pt)) ? et + 1'b1 : et;
    end
    return r;
  endfunction

  function automatic logic [CB-1:0] sat_add(logic [CB-1:0] a, logic [7:0] b);
    logic [CB:0] s;
    s = {1'b0, a} + (CB+1)'(b);
    return s[CB] ? '1 : s[CB-1:0];
  endfunction

  // Divider step and dose result.
  logic [DOSE_BITS:0]   rem_sh;
  logic                 qbit;
  logic [DOSE_BITS-1:0] dose_res;

  always_comb begin
    rem_sh = {rem_q, prod_q[PW-1]};
    qbit = rem_sh >= {1'b0, rate_q};
    if (rate_q == '0) begin
      dose_res = '1;
    end else if (prod_q > PW'(DOSE_QUOT_MAX)) begin
      dose_res = '1;
    end else begin
      dose_res = DOSE_BITS'(prod_q[9:0]) * DOSE_BITS'(DOSE_SCALE);
    end
  end

  assign status_o.div_last = (dcnt_q == DCW'(PW - 1));

  // One control tick, evaluated in model order.
  logic fresh;
  tm_t ok_n, bad_n, err_n, ref_n, saf_n, fs_n, fg_n, cut_n, pe_n;
  logic [DOSE_BITS-1:0] calc_n, held_n, plen_n, left_n;
  logic [CB-1:0] plate_n, area_n;
  logic lnr, valve, pump, cmd, refill, flowf, req, pa, trig, ok_f, bad_f, err_f;
  logic clk_vf, fall_vf, ref_f, saf_f, cmd_r, cut_f, lalarm_n;

  always_comb begin
    fresh = (mode_q == MODE_FRESH);
    lnr = f_lnr_q;
    ok_n = od_next(ok_et_q, full_q, LEVEL_DEBOUNCE_TICKS);
    bad_n = od_next(bad_et_q, !full_q, LEVEL_DEBOUNCE_TICKS);
    ok_f = ok_n >= TB'(LEVEL_DEBOUNCE_TICKS);
    bad_f = bad_n >= TB'(LEVEL_DEBOUNCE_TICKS);
    if (ok_f && !m_lok_q) lnr = 1'b0;
    if (bad_f && !m_lbad_q) lnr = 1'b1;
    err_n = od_next(err_et_q, lnr, LEVEL_ERROR_TICKS);
    err_f = err_n >= TB'(LEVEL_ERROR_TICKS);
    lalarm_n = module_q && err_f && !fresh;

    calc_n = last_q;
    trig = 1'b0;
    plate_n = plate_q;
    area_n = area_q;
    if (pulse_q && proc_q && mode_q == MODE_PER_PLATE) begin
      calc_n = dose_res;
      if (dose_res >= min_time_q) begin
        trig = 1'b1;
        plate_n = '0;
      end
    end
    if (pulse_q && proc_q && mode_q == MODE_PER_AREA) begin
      calc_n = dose_res;
      if (dose_res >= min_time_q) begin
        trig = 1'b1;
        area_n = '0;
      end
    end
    held_n = f_valve_q ? held_q : calc_n;
    plen_n = (trig && !f_valve_q) ? held_n : plen_q;
    if (f_valve_q && (32'(plen_n) > 32'(pe_q))) begin
      left_n = DOSE_BITS'(32'(plen_n) - 32'(pe_q));
    end else begin
      left_n = '0;
    end

    pa = pa_q;
    pe_n = pe_q;
    if (pa_q) begin
      if (pe_q != '1) pe_n = pe_q + 1'b1;
      if (32'(pe_n) >= 32'(plen_n)) pa = 1'b0;
    end else if (trig && !m_tpin_q) begin
      pe_n = '0;
      pa = (plen_n != '0);
    end else if (!trig) begin
      pe_n = '0;
    end

    valve = f_valve_q;
    if (pa && !m_vr_q && !fresh) valve = 1'b1;
    clk_vf = pa && auto_q;
    fall_vf = !clk_vf && m_vf_q;
    if ((fall_vf && !fresh) || !volt_q) valve = 1'b0;

    ref_n = od_next(ref_et_q, req_q, REFILL_TICKS);
    ref_f = ref_n >= TB'(REFILL_TICKS);
    refill = f_refill_q;
    if (!fresh) begin
      req = !lnr;
      if (lnr && volt_q && auto_q) begin
        valve = 1'b1;
        refill = 1'b1;
      end
      if ((ref_f || !auto_q) && refill) begin
        refill = 1'b0;
        valve = 1'b0;
      end
    end else begin
      req = 1'b0;
      refill = 1'b0;
    end

    saf_n = od_next(saf_et_q, valve && full_q, SAFETY_TICKS);
    saf_f = saf_n >= TB'(SAFETY_TICKS);
    if (saf_f) valve = 1'b0;

    cmd = f_cmd_q;
    cmd_r = cmd && !m_pr_q;

    fs_n = fs_et_q;
    fg_n = fg_et_q;
    flowf = f_flow_q;
    if (fce_q) begin
      if (fresh) begin
        fs_n = od_next(fs_et_q, valve, FLOW_START_TICKS);
        if ((fs_n >= TB'(FLOW_START_TICKS)) && !flow_q) flowf = 1'b1;
      end else begin
        fs_n = od_next(fs_et_q, f_pump_q, FLOW_START_TICKS);
        fg_n = od_next(fg_et_q, !flow_q && !valve, FLOW_GAP_TICKS);
        if ((fs_n >= TB'(FLOW_START_TICKS)) && (fg_n >= TB'(FLOW_GAP_TICKS))) begin
          flowf = 1'b1;
        end
      end
    end else begin
      flowf = 1'b0;
    end

    cut_n = od_next(cut_et_q, lnr && !cmd_r, PUMP_CUT_TICKS);
    cut_f = cut_n >= TB'(PUMP_CUT_TICKS);
    if (cut_f || !volt_q || flowf) begin
      pump = 1'b0;
      cmd = 1'b0;
    end else begin
      pump = cmd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= '0;
      dose_plate_q <= '0;
      dose_area_q <= '0;
      rate_q <= DOSE_BITS'(1);
      min_time_q <= '0;
      fce_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_REPLENISH_MODE: mode_q <= cfg_data_i[1:0];
        REG_DOSE_PER_PLATE: dose_plate_q <= cfg_data_i;
        REG_DOSE_PER_AREA:  dose_area_q <= cfg_data_i;
        REG_PUMP_RATE:      rate_q <= cfg_data_i;
        REG_MIN_VALVE_TIME: min_time_q <= cfg_data_i;
        REG_FLOW_CHECK_EN:  fce_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      full_q <= tank_full_i;
      pulse_q <= second_pulse_i;
      proc_q <= processing_i;
      module_q <= module_present_i;
      volt_q <= voltage_ok_i;
      auto_q <= auto_mode_i;
      flow_q <= flow_present_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_q <= '0;
      rem_q <= '0;
      dcnt_q <= '0;
    end else if (cmd_i.mul) begin
      prod_q <= (mode_q == MODE_PER_AREA) ? PW'(area_q) * PW'(dose_area_q)
                                          : PW'(plate_q) * PW'(dose_plate_q);
      rem_q <= '0;
      dcnt_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= qbit ? DOSE_BITS'(rem_sh - {1'b0, rate_q}) : rem_sh[DOSE_BITS-1:0];
      prod_q <= {prod_q[PW-2:0], qbit};
      dcnt_q <= dcnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ok_et_q <= '0; bad_et_q <= '0; err_et_q <= '0; ref_et_q <= '0;
      saf_et_q <= '0; fs_et_q <= '0; fg_et_q <= '0; cut_et_q <= '0;
      pe_q <= '0; plen_q <= '0; last_q <= '0; held_q <= '0;
      pa_q <= 1'b0; req_q <= 1'b0;
      m_lok_q <= 1'b0; m_lbad_q <= 1'b0; m_vr_q <= 1'b0;
      m_vf_q <= 1'b0; m_pr_q <= 1'b0; m_tpin_q <= 1'b0;
      plate_q <= '0; area_q <= '0;
      f_lnr_q <= 1'b0; f_valve_q <= 1'b0; f_pump_q <= 1'b0;
      f_cmd_q <= 1'b0; f_refill_q <= 1'b0; f_flow_q <= 1'b0;
      lalarm_q <= 1'b0; left_q <= '0;
    end else if (cmd_i.load) begin
      plate_q <= sat_add(plate_q, plates_added_i);
      area_q <= sat_add(area_q, area_added_i);
      if (pump_write_i) f_cmd_q <= pump_write_value_i;
    end else if (cmd_i.apply) begin
      ok_et_q <= ok_n; bad_et_q <= bad_n; err_et_q <= err_n; ref_et_q <= ref_n;
      saf_et_q <= saf_n; fs_et_q <= fs_n; fg_et_q <= fg_n; cut_et_q <= cut_n;
      pe_q <= pe_n; plen_q <= plen_n; last_q <= calc_n; held_q <= held_n;
      pa_q <= pa; req_q <= req;
      m_lok_q <= ok_f; m_lbad_q <= bad_f; m_vr_q <= pa;
      m_vf_q <= clk_vf; m_pr_q <= f_cmd_q; m_tpin_q <= trig;
      plate_q <= plate_n; area_q <= area_n;
      f_lnr_q <= lnr; f_valve_q <= valve; f_pump_q <= pump;
      f_cmd_q <= cmd; f_refill_q <= refill; f_flow_q <= flowf;
      lalarm_q <= lalarm_n; left_q <= left_n;
    end
  end

  assign valve_open_o = f_valve_q;
  assign pump_on_o = f_pump_q;
  assign pump_command_o = f_cmd_q;
  assign level_out_of_range_o = f_lnr_q;
  assign level_alarm_o = lalarm_q;
  assign flow_alarm_o = f_flow_q;
  assign dose_time_o = held_q;
  assign dose_time_left_o = left_q;
  assign refilling_o = f_refill_q;

  // A level alarm needs the not-in-range flag that timed it.
  a_alarm_lnr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lalarm_q |-> f_lnr_q) else $error("level alarm without level flag");

  // A pulse ends at or before its length.
  a_pulse_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pa_q |-> (32'(pe_q) < 32'(plen_q))) else $error("pulse ran past its length");

  // The divider produces exactly one quotient bit per step.
  a_div_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |=> (dcnt_q == $past(dcnt_q) + 1'b1))
    else $error("divider step count slipped");

endmodule

// File: src/tpc_controller.sv
// Controller state machine sequencing load, multiply, divide, update and output.
module tpc_controller
  import tpc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  input  tpc_status_t status_i,
  output tpc_cmd_t    cmd_o
);

  tpc_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) state_d = ST_APPLY;
      end
      ST_APPLY: begin
        cmd_o.apply = 1'b1;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("item taken while result pending");

  a_load_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> cmd_o.mul) else $error("load not followed by multiply");

  a_apply_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.apply |=> out_valid_o) else $error("update not followed by result");

endmodule

// File: tb/testbench.sv
// Self-checking testbench of the prewash tank controller core.
module testbench
  import tpc_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int TMAX = 65535;

  typedef struct packed {
    logic       tank_full;
    logic       second_pulse;
    logic       processing;
    logic       module_present;
    logic       voltage_ok;
    logic       auto_mode;
    logic       flow_present;
    logic [7:0] plates_added;
    logic [7:0] area_added;
    logic       pump_write;
    logic       pump_write_value;
  } tick_t;

  typedef struct packed {
    logic        valve_open;
    logic        pump_on;
    logic        pump_command;
    logic        level_out_of_range;
    logic        level_alarm;
    logic        flow_alarm;
    logic [15:0] dose_time;
    logic [15:0] dose_time_left;
    logic        refilling;
  } tank_status_t;

  logic clk_i;
  logic rst_ni;

  tpc_in_if  in_ch ();
  tpc_out_if out_ch ();
  tpc_cfg_if cfg_ch ();

  tank_prewash_controller_core i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch),
    .cfg_i (cfg_ch)
  );

  // Predictor copy of the configuration.
  tpc_mode_e   mode_q;
  logic [15:0] plate_dose_q, area_dose_q, rate_q, min_time_q;
  logic        flow_chk_q;

  // Predictor copy of the block state.
  int unsigned ok_cnt, bad_cnt, err_cnt, refill_cnt, safety_cnt;
  int unsigned flow_start_cnt, flow_gap_cnt, cut_cnt, pulse_cnt, pulse_len;
  bit          pulse_on, refill_req;
  bit          ok_prev, bad_prev, valve_rise_prev, valve_fall_prev, cmd_prev, trig_prev;
  int unsigned plates, area, dose_calc, dose_held;
  bit          lnr, valve, pump, cmd, refill, flow_alm;

  tank_status_t expected_status_q[$];
  int           mismatch_count;
  int           idle_cycles;
  int           stall_left;
  bit           idle_enable;
  bit           timed_out;

  initial begin
    clk_i = 1'b0;
    forever #4ns clk_i = ~clk_i;
  end

  function automatic bit delay_on(ref int unsigned cnt, input bit en, input int unsigned preset);
    if (!en) begin
      cnt = 0;
      return 1'b0;
    end
    if (cnt < preset && cnt < TMAX) cnt++;
    return cnt >= preset;
  endfunction

  function automatic bit rising(ref bit prev, input bit cur);
    bit r;
    r = cur && !prev;
    prev = cur;
    return r;
  endfunction

  function automatic int unsigned dose_for(int unsigned count, int unsigned dose);
    longint unsigned v;
    if (rate_q == 0) return 65535;
    v = (longint'(count) * dose / rate_q) * 100;
    return (v > 65535) ? 65535 : int'(v);
  endfunction

  task automatic reset_model();
    mode_q = MODE_PER_PLATE; plate_dose_q = 0; area_dose_q = 0; rate_q = 1;
    min_time_q = 0; flow_chk_q = 0;
    ok_cnt = 0; bad_cnt = 0; err_cnt = 0; refill_cnt = 0; safety_cnt = 0;
    flow_start_cnt = 0; flow_gap_cnt = 0; cut_cnt = 0; pulse_cnt = 0; pulse_len = 0;
    pulse_on = 0; refill_req = 0;
    ok_prev = 0; bad_prev = 0; valve_rise_prev = 0; valve_fall_prev = 0;
    cmd_prev = 0; trig_prev = 0;
    plates = 0; area = 0; dose_calc = 0; dose_held = 0;
    lnr = 0; valve = 0; pump = 0; cmd = 0; refill = 0; flow_alm = 0;
  endtask

  function automatic tank_status_t predict_tick(tick_t t);
    tank_status_t r;
    bit fresh, ok_q, bad_q, err_q, trig, ref_q, saf_q, cmd_r, cut_q, clk, fall, sq, dq;
    int unsigned left;
    fresh = (mode_q == MODE_FRESH);
    trig = 0;
    plates = (plates + t.plates_added > 65535) ? 65535 : plates + t.plates_added;
    area = (area + t.area_added > 65535) ? 65535 : area + t.area_added;
    if (t.pump_write) cmd = t.pump_write_value;

    ok_q = delay_on(ok_cnt, t.tank_full, LEVEL_DEBOUNCE_TICKS);
    bad_q = delay_on(bad_cnt, !t.tank_full, LEVEL_DEBOUNCE_TICKS);
    if (rising(ok_prev, ok_q)) lnr = 0;
    if (rising(bad_prev, bad_q)) lnr = 1;
    err_q = delay_on(err_cnt, lnr, LEVEL_ERROR_TICKS);
    r.level_alarm = t.module_present && err_q && !fresh;

    if (t.second_pulse && t.processing && mode_q == MODE_PER_PLATE) begin
      dose_calc = dose_for(plates, plate_dose_q);
      if (dose_calc >= min_time_q) begin
        trig = 1; plates = 0;
      end
    end
    if (t.second_pulse && t.processing && mode_q == MODE_PER_AREA) begin
      dose_calc = dose_for(area, area_dose_q);
      if (dose_calc >= min_time_q) begin
        trig = 1; area = 0;
      end
    end
    if (!valve) dose_held = dose_calc;
    if (trig && !valve) pulse_len = dose_held;
    left = (valve && pulse_len > pulse_cnt) ? pulse_len - pulse_cnt : 0;

    if (pulse_on) begin
      if (pulse_cnt < TMAX) pulse_cnt++;
      if (pulse_cnt >= pulse_len) pulse_on = 0;
    end else if (trig && !trig_prev) begin
      pulse_cnt = 0;
      pulse_on = pulse_len > 0;
    end else if (!trig) begin
      pulse_cnt = 0;
    end
    trig_prev = trig;

    if (rising(valve_rise_prev, pulse_on) && !fresh) valve = 1;
    clk = pulse_on && t.auto_mode;
    fall = !clk && valve_fall_prev;
    valve_fall_prev = clk;
    if ((fall && !fresh) || !t.voltage_ok) valve = 0;

    ref_q = delay_on(refill_cnt, refill_req, REFILL_TICKS);
    if (!fresh) begin
      refill_req = !lnr;
      if (lnr && t.voltage_ok && t.auto_mode) begin
        valve = 1; refill = 1;
      end
      if ((ref_q || !t.auto_mode) && refill) begin
        refill = 0; valve = 0;
      end
    end else begin
      refill_req = 0;
      refill = 0;
    end

    saf_q = delay_on(safety_cnt, valve && t.tank_full, SAFETY_TICKS);
    if (saf_q) valve = 0;
    cmd_r = rising(cmd_prev, cmd);

    if (flow_chk_q) begin
      if (fresh) begin
        if (delay_on(flow_start_cnt, valve, FLOW_START_TICKS) && !t.flow_present)
          flow_alm = 1;
      end else begin
        sq = delay_on(flow_start_cnt, pump, FLOW_START_TICKS);
        dq = delay_on(flow_gap_cnt, !t.flow_present && !valve, FLOW_GAP_TICKS);
        if (sq && dq) flow_alm = 1;
      end
    end else begin
      flow_alm = 0;
    end

    cut_q = delay_on(cut_cnt, lnr && !cmd_r, PUMP_CUT_TICKS);
    if (cut_q || !t.voltage_ok || flow_alm) begin
      pump = 0; cmd = 0;
    end else begin
      pump = cmd;
    end

    r.valve_open = valve; r.pump_on = pump; r.pump_command = cmd;
    r.level_out_of_range = lnr; r.flow_alarm = flow_alm;
    r.dose_time = dose_held[15:0]; r.dose_time_left = left[15:0];
    r.refilling = refill;
    return r;
  endfunction

  // The input stays valid between items unless an idle burst drops it.
  task automatic idle_burst();
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic send_tick(tick_t t);
    idle_burst();
    in_ch.valid <= 1'b1;
    {in_ch.tank_full, in_ch.second_pulse, in_ch.processing, in_ch.module_present,
     in_ch.voltage_ok, in_ch.auto_mode, in_ch.flow_present, in_ch.plates_added,
     in_ch.area_added, in_ch.pump_write, in_ch.pump_write_value} <= t;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    expected_status_q.push_back(predict_tick(t));
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_status_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_reg(tpc_reg_e idx, logic [15:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    case (idx)
      REG_REPLENISH_MODE: mode_q = tpc_mode_e'(value[1:0]);
      REG_DOSE_PER_PLATE: plate_dose_q = value;
      REG_DOSE_PER_AREA:  area_dose_q = value;
      REG_PUMP_RATE:      rate_q = value;
      REG_MIN_VALVE_TIME: min_time_q = value;
      REG_FLOW_CHECK_EN:  flow_chk_q = value[0];
      default: ;
    endcase
  endtask

  task automatic configure(tpc_mode_e m, logic [15:0] pd, logic [15:0] ad,
                           logic [15:0] pr, logic [15:0] mv, logic fc);
    wait_drained();
    write_reg(REG_REPLENISH_MODE, 16'(m));
    write_reg(REG_DOSE_PER_PLATE, pd);
    write_reg(REG_DOSE_PER_AREA, ad);
    write_reg(REG_PUMP_RATE, pr);
    write_reg(REG_MIN_VALVE_TIME, mv);
    write_reg(REG_FLOW_CHECK_EN, 16'(fc));
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic tick_t random_tick(int full_bias);
    tick_t t;
    t = tick_t'($urandom());
    t.tank_full = ($urandom_range(0, 99) < full_bias);
    t.voltage_ok = ($urandom_range(0, 15) != 0);
    t.auto_mode = ($urandom_range(0, 7) != 0);
    t.second_pulse = ($urandom_range(0, 9) == 0);
    t.pump_write = ($urandom_range(0, 9) == 0);
    if ($urandom_range(0, 3) != 0) t.plates_added = 8'($urandom_range(0, 3));
    if ($urandom_range(0, 3) != 0) t.area_added = 8'($urandom_range(0, 3));
    return t;
  endfunction

  task automatic test_directed_extremes();
    tick_t t;
    configure(MODE_PER_PLATE, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 1'b1);
    t = '1;
    send_tick(t);
    t = '0;
    send_tick(t);
    configure(MODE_PER_PLATE, 16'd5, 16'd7, 16'd1, 16'd0, 1'b0);
    // Repeated pulses with processing exercise the dose pulse and its restart.
    for (int i = 0; i < 12; i++) begin
      t = '0;
      t.tank_full = 1; t.voltage_ok = 1; t.auto_mode = 1; t.processing = 1;
      t.second_pulse = (i % 3 == 0);
      t.plates_added = (i == 0) ? 8'hFF : 8'd1;
      t.pump_write = (i == 1); t.pump_write_value = 1;
      send_tick(t);
    end
    configure(MODE_SPARE, 16'd1, 16'd1, 16'd1, 16'hFFFF, 1'b1);
    t = '1;
    send_tick(t);
    configure(MODE_FRESH, 16'd1, 16'd1, 16'hFFFF, 16'd3, 1'b1);
    t = '1;
    t.tank_full = 0;
    send_tick(t);
  endtask

  // Stretches of a level biased towards full or empty exercise the debounce, alarm, refill and cut-off timers.
  task automatic test_random_mode(tpc_mode_e m, int n, logic fc);
    int full_bias;
    configure(m, 16'($urandom_range(0, 40)), 16'($urandom_range(0, 40)),
              16'($urandom_range(1, 8)), 16'($urandom_range(0, 300)), fc);
    for (int i = 0; i < n; i++) begin
      if (i % 700 == 0) full_bias = (($urandom_range(0, 1)) != 0) ? 97 : 3;
      send_tick(random_tick(full_bias));
    end
  endtask

  task automatic test_saturation();
    tick_t t;
    configure(MODE_PER_AREA, 16'hFFFF, 16'hFFFF, 16'd1, 16'hFFFF, 1'b0);
    for (int i = 0; i < 300; i++) begin
      t = random_tick(50);
      t.plates_added = 8'hFF; t.area_added = 8'hFF;
      t.processing = 1;
      send_tick(t);
    end
  endtask

  always @(posedge clk_i) begin
    tank_status_t got, want;
    if (out_ch.valid && out_ch.ready) begin
      got = {out_ch.valve_open, out_ch.pump_on, out_ch.pump_command,
             out_ch.level_out_of_range, out_ch.level_alarm, out_ch.flow_alarm,
             out_ch.dose_time, out_ch.dose_time_left, out_ch.refilling};
      if (expected_status_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result %p", got);
      end else begin
        want = expected_status_q.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  // Ready stalls are inserted at random while idle bursts are enabled.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_enable && $urandom_range(0, 5) == 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= int'($urandom_range(0, 3));
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT && !timed_out) begin
      timed_out <= 1'b1;
      $display("testbench failed");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    {in_ch.tank_full, in_ch.second_pulse, in_ch.processing, in_ch.module_present,
     in_ch.voltage_ok, in_ch.auto_mode, in_ch.flow_present, in_ch.plates_added,
     in_ch.area_added, in_ch.pump_write, in_ch.pump_write_value} = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_REPLENISH_MODE;
    cfg_ch.data = '0;
    mismatch_count = 0;
    idle_cycles = 0;
    timed_out = 0;
    idle_enable = 1;
    reset_model();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_extremes();
    test_random_mode(MODE_PER_PLATE, 500, 1'b1);
    test_random_mode(MODE_PER_AREA, 500, 1'b0);
    test_random_mode(MODE_FRESH, 400, 1'b1);
    test_saturation();
    idle_enable = 0;
    test_random_mode(MODE_SPARE, 300, 1'b1);
    wait_drained();
    if (mismatch_count == 0 && expected_status_q.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end
endmodule
